FILE: src/scrs_pkg.sv
package scrs_pkg;

    localparam int BYTE_W     = 8;
    localparam int NIB_W      = 4;
    localparam int COEFF_W    = 3;
    localparam int INDEX_W    = 10;
    localparam int ETA_W      = 2;
    localparam int TARGET_W   = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int MAX_DIGITS = 5;
    localparam int CNT_W      = 3;
    localparam int M_TDATA_W  = 16;

    localparam int MAX_COEFFS_DEF = 1024;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ETA_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 1'd1;

    localparam logic [ETA_W-1:0]    ETA_MODE_1   = 2'd1;
    localparam logic [ETA_W-1:0]    ETA_MODE_2   = 2'd2;
    localparam logic [TARGET_W-1:0] TARGET_RESET = 11'd256;

    localparam logic [BYTE_W-1:0] ETA1_BOUND = 8'd243;
    localparam logic [NIB_W-1:0]  NIB_REJECT = 4'hf;

    // Reciprocal multipliers: x/3 = (x*171)>>9 for x < 256, x/5 = (x*205)>>10 for x < 16.
    localparam int DIV3_MUL   = 171;
    localparam int DIV3_SHIFT = 9;
    localparam int DIV5_MUL   = 205;
    localparam int DIV5_SHIFT = 10;

    typedef struct packed {
        logic [MAX_DIGITS-1:0][COEFF_W-1:0] coef;
        logic [CNT_W-1:0]                   cnt;
        logic                               fin;
    } cand_t;

    function automatic logic [BYTE_W-1:0] div3(input logic [BYTE_W-1:0] t);
        logic [15:0] p;
        p = 16'(t) * 16'(DIV3_MUL);
        return BYTE_W'(p >> DIV3_SHIFT);
    endfunction

    function automatic logic [COEFF_W-1:0] eta1_value(input logic [1:0] digit);
        return (digit == 2'd2) ? 3'b111 : {1'b0, digit};
    endfunction

    function automatic logic [COEFF_W-1:0] eta2_value(input logic [NIB_W-1:0] nib);
        logic [11:0] p;
        logic [NIB_W-1:0] q;
        logic [NIB_W-1:0] r;
        p = 12'(nib) * 12'(DIV5_MUL);
        q = NIB_W'(p >> DIV5_SHIFT);
        r = NIB_W'(nib - NIB_W'(q * 4'd5));
        return COEFF_W'(3'd2 - r[COEFF_W-1:0]);
    endfunction

endpackage

FILE: src/small_coefficient_rejection_sampler_unit.sv
// Channel   Direction  Payload
// s_*       in         tdata[7:0] rand_byte, tlast final_byte
// m_*       out        tdata[2:0] coeff, tdata[12:3] coeff_index; tlast last_of_byte;
//                      tuser target_reached
// cfg_*     in         cfg_index 0 eta_mode, 1 target_count; cfg_data[10:0]
//
// A byte yields n coefficients (0 to 5); the single result register sends one coefficient
// per cycle while m_tready does not stall it.
// The first coefficient of a byte passes the input register, the emitter item register and
// the result register before it is offered on m_tvalid.
// Reset sets eta_mode to 1, target_count to 256 and clears the coefficient count.
// A stalled output holds its coefficient while the next byte waits in the emitter
// and one more in the input register.
module small_coefficient_rejection_sampler_unit #(
    parameter int MAX_COEFFS = scrs_pkg::MAX_COEFFS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [scrs_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] rand_byte
    input  logic                            s_tlast,   // final_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [scrs_pkg::M_TDATA_W-1:0]  m_tdata,   // [2:0] coeff, [12:3] coeff_index
    output logic                            m_tlast,   // last_of_byte
    output logic                            m_tuser,   // target_reached
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scrs_pkg::TARGET_W-1:0]   cfg_data
);

    logic                            a_valid_reg;
    logic [scrs_pkg::BYTE_W-1:0]     a_byte_reg;
    logic                            a_fin_reg;
    logic [scrs_pkg::ETA_W-1:0]      eta_mode_reg;
    logic [scrs_pkg::TARGET_W-1:0]   target_reg;
    scrs_pkg::cand_t                 cand;
    logic                            em_ready;

    assign cfg_ready = 1'b1;
    assign s_tready  = !a_valid_reg || em_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_mode_reg <= scrs_pkg::ETA_MODE_1;
            target_reg   <= scrs_pkg::TARGET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                scrs_pkg::CFG_ETA_MODE: eta_mode_reg <= cfg_data[scrs_pkg::ETA_W-1:0];
                scrs_pkg::CFG_TARGET:   target_reg   <= cfg_data;
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (em_ready)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            a_byte_reg <= s_tdata;
            a_fin_reg  <= s_tlast;
        end
    end

    scrs_decode u_decode (
        .rand_byte  (a_byte_reg),
        .final_byte (a_fin_reg),
        .eta_mode   (eta_mode_reg),
        .cand       (cand)
    );

    scrs_emitter #(
        .MAX_COEFFS (MAX_COEFFS)
    ) u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (a_valid_reg),
        .load_item    (cand),
        .load_ready   (em_ready),
        .target_count (target_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

    // Filling the target always ends the coefficients of that byte.
    a_reached_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("target reached without last_of_byte");

    // The codes for 3 and -4 may not leave the sampler.
    a_coeff_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] != 3'b011) && (m_tdata[2:0] != 3'b100))
        else $error("coefficient out of range");

    // Input back-pressure only comes from a held byte that the emitter cannot take.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> a_valid_reg && !em_ready)
        else $error("input stalled with free input register");

endmodule

FILE: src/scrs_decode.sv
module scrs_decode (
    input  logic [scrs_pkg::BYTE_W-1:0] rand_byte,
    input  logic                        final_byte,
    input  logic [scrs_pkg::ETA_W-1:0]  eta_mode,
    output scrs_pkg::cand_t             cand
);

    always_comb
    begin
        logic [scrs_pkg::BYTE_W-1:0] t;
        logic [scrs_pkg::BYTE_W-1:0] q;
        logic [scrs_pkg::NIB_W-1:0]  lo;
        logic [scrs_pkg::NIB_W-1:0]  hi;
        logic [1:0]                  digit;

        cand     = '0;
        cand.fin = final_byte;
        t        = rand_byte;
        lo       = rand_byte[3:0];
        hi       = rand_byte[7:4];
        q        = '0;
        digit    = '0;

        if (eta_mode == scrs_pkg::ETA_MODE_2)
        begin
            if (lo != scrs_pkg::NIB_REJECT)
            begin
                cand.coef[0] = scrs_pkg::eta2_value(lo);
                cand.cnt     = 3'd1;
            end
            if (hi != scrs_pkg::NIB_REJECT)
            begin
                cand.coef[cand.cnt] = scrs_pkg::eta2_value(hi);
                cand.cnt            = 3'(cand.cnt + 3'd1);
            end
        end
        else if (rand_byte < scrs_pkg::ETA1_BOUND)
        begin
            // Base-3 digits, least significant first.
            for (int i = 0; i < scrs_pkg::MAX_DIGITS; i++)
            begin
                q            = scrs_pkg::div3(t);
                digit        = 2'(t - 8'(q * 8'd3));
                cand.coef[i] = scrs_pkg::eta1_value(digit);
                t            = q;
            end
            cand.cnt = 3'(scrs_pkg::MAX_DIGITS);
        end
    end

endmodule

FILE: src/scrs_emitter.sv
module scrs_emitter #(
    parameter int MAX_COEFFS = scrs_pkg::MAX_COEFFS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load_valid,
    input  scrs_pkg::cand_t               load_item,
    output logic                          load_ready,
    input  logic [scrs_pkg::TARGET_W-1:0] target_count,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [scrs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    output logic                          m_tuser
);

    localparam int CW = $clog2(MAX_COEFFS + 1);
    localparam int LW = (CW > scrs_pkg::TARGET_W) ? CW : scrs_pkg::TARGET_W;

    logic                              em_valid_reg;
    scrs_pkg::cand_t                   em_item_reg;
    logic [scrs_pkg::CNT_W-1:0]        em_ptr_reg;
    logic [CW-1:0]                     cnt_reg;
    logic [CW-1:0]                     cnt_next;
    logic                              out_valid_reg;
    logic [scrs_pkg::COEFF_W-1:0]      out_coeff_reg;
    logic [scrs_pkg::INDEX_W-1:0]      out_index_reg;
    logic                              out_last_reg;
    logic                              out_reached_reg;

    logic [LW-1:0]                     limit;
    logic [CW-1:0]                     cnt_inc;
    logic [scrs_pkg::CNT_W-1:0]        ptr_inc;
    logic                              have_cand;
    logic                              below;
    logic                              out_free;
    logic                              emit;
    logic                              reached;
    logic                              last;
    logic                              finish;

    assign limit     = (LW'(target_count) > LW'(MAX_COEFFS)) ? LW'(MAX_COEFFS)
                                                             : LW'(target_count);
    assign cnt_inc   = cnt_reg + CW'(1);
    assign ptr_inc   = em_ptr_reg + scrs_pkg::CNT_W'(1);
    assign have_cand = em_ptr_reg < em_item_reg.cnt;
    assign below     = LW'(cnt_reg) < limit;
    assign out_free  = !out_valid_reg || m_tready;
    assign emit      = em_valid_reg && have_cand && below && out_free;
    assign reached   = LW'(cnt_inc) == limit;
    assign last      = (ptr_inc == em_item_reg.cnt) || reached;

    // An item is done after its last coefficient, or at once when nothing is left to send.
    assign finish     = em_valid_reg && (emit ? last : !(have_cand && below));
    assign load_ready = !em_valid_reg || finish;

    always_comb
    begin
        cnt_next = emit ? cnt_inc : cnt_reg;
        if (finish && em_item_reg.fin)
        begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_valid_reg  <= 1'b0;
            em_ptr_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (load_ready && load_valid)
            begin
                em_valid_reg <= 1'b1;
                em_ptr_reg   <= '0;
            end
            else if (finish)
            begin
                em_valid_reg <= 1'b0;
            end
            else if (emit)
            begin
                em_ptr_reg <= ptr_inc;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
        begin
            em_item_reg <= load_item;
        end
        if (emit)
        begin
            out_coeff_reg   <= em_item_reg.coef[em_ptr_reg];
            out_index_reg   <= scrs_pkg::INDEX_W'(cnt_reg);
            out_last_reg    <= last;
            out_reached_reg <= reached;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = scrs_pkg::M_TDATA_W'({out_index_reg, out_coeff_reg});
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_reached_reg;

endmodule

FILE: tb/small_coefficient_rejection_sampler_unit_tb.sv
module small_coefficient_rejection_sampler_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COEFFS    = scrs_pkg::MAX_COEFFS_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;

    typedef struct packed {
        logic [scrs_pkg::COEFF_W-1:0] coeff;
        logic [scrs_pkg::INDEX_W-1:0] index;
        logic                         last;
        logic                         reached;
    } coeff_rec_t;

    typedef enum logic [1:0] {
        STEP_BYTE,
        STEP_CFG
    } step_kind_t;

    typedef struct packed {
        step_kind_t                                             kind;
        logic [scrs_pkg::CFG_IDX_W-1:0]                         reg_idx;
        logic [scrs_pkg::TARGET_W-1:0]                          reg_val;
        logic [scrs_pkg::BYTE_W-1:0]                            rand_byte;
        logic                                                   final_byte;
        logic                                                   known;
        logic [scrs_pkg::MAX_DIGITS-1:0][scrs_pkg::COEFF_W-1:0] known_coeffs;
    } step_t;

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [scrs_pkg::BYTE_W-1:0]      s_tdata;
    logic                             s_tlast;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [scrs_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             m_tlast;
    logic                             m_tuser;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [scrs_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [scrs_pkg::TARGET_W-1:0]    cfg_data;

    // Mirror of the sampler state.
    logic [scrs_pkg::ETA_W-1:0]       eta_sel;
    logic [scrs_pkg::TARGET_W-1:0]    target_sel;
    logic [scrs_pkg::TARGET_W-1:0]    coeff_count;

    coeff_rec_t             pending_coeffs[$];
    step_t                  script[$];
    int                     errors;
    int                     send_idle_pct;
    int                     ready_stall_pct;
    int                     quiet_cycles;
    logic                   sent_since_drain;

    small_coefficient_rejection_sampler_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Expected coefficients of one accepted byte, appended to pending_coeffs.
    // Where the table gives the coefficient values, they replace the computed ones.
    function automatic void sample_byte(
        input logic [scrs_pkg::BYTE_W-1:0] rand_byte,
        input logic final_byte,
        input logic known,
        input logic [scrs_pkg::MAX_DIGITS-1:0][scrs_pkg::COEFF_W-1:0] known_coeffs);
        logic [scrs_pkg::COEFF_W-1:0] cand[scrs_pkg::MAX_DIGITS];
        coeff_rec_t                   outs[scrs_pkg::MAX_DIGITS];
        logic [scrs_pkg::NIB_W-1:0]   nib;
        logic [scrs_pkg::BYTE_W-1:0]  rest;
        int                           ncand;
        int                           n;
        int                           limit;
        int                           digit;

        ncand = 0;
        n = 0;
        limit = (int'(target_sel) > MAX_COEFFS) ? MAX_COEFFS : int'(target_sel);
        if (eta_sel == scrs_pkg::ETA_MODE_2)
        begin
            for (int h = 0; h < 2; h++)
            begin
                nib = (h == 0) ? rand_byte[3:0] : rand_byte[7:4];
                if (nib != scrs_pkg::NIB_REJECT)
                begin
                    cand[ncand] = scrs_pkg::COEFF_W'(2 - int'(nib % 5));
                    ncand++;
                end
            end
        end
        else if (rand_byte < scrs_pkg::ETA1_BOUND)
        begin
            // Modes 0 and 3 fall back to base-3 digit extraction.
            rest = rand_byte;
            for (int k = 0; k < scrs_pkg::MAX_DIGITS; k++)
            begin
                digit = int'(rest % 3);
                cand[ncand] = (digit == 2) ? 3'b111 : scrs_pkg::COEFF_W'(digit);
                ncand++;
                rest = rest / 3;
            end
        end

        for (int k = 0; k < ncand && int'(coeff_count) < limit; k++)
        begin
            outs[n].coeff   = known ? known_coeffs[k] : cand[k];
            outs[n].index   = coeff_count[scrs_pkg::INDEX_W-1:0];
            outs[n].last    = 1'b0;
            coeff_count     = coeff_count + 1'b1;
            outs[n].reached = (int'(coeff_count) == limit);
            n++;
        end
        if (n > 0)
            outs[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            pending_coeffs.push_back(outs[k]);

        if (final_byte)
            coeff_count = '0;
    endfunction

    function automatic step_t byte_row(input logic [scrs_pkg::BYTE_W-1:0] b,
                                       input logic fin);
        step_t s;
        s = '0;
        s.kind = STEP_BYTE;
        s.rand_byte = b;
        s.final_byte = fin;
        return s;
    endfunction

    function automatic step_t known_row(input logic [scrs_pkg::BYTE_W-1:0] b,
                                        input logic fin,
                                        input int c0, input int c1, input int c2,
                                        input int c3, input int c4);
        step_t s;
        s = byte_row(b, fin);
        s.known = 1'b1;
        s.known_coeffs[0] = scrs_pkg::COEFF_W'(c0);
        s.known_coeffs[1] = scrs_pkg::COEFF_W'(c1);
        s.known_coeffs[2] = scrs_pkg::COEFF_W'(c2);
        s.known_coeffs[3] = scrs_pkg::COEFF_W'(c3);
        s.known_coeffs[4] = scrs_pkg::COEFF_W'(c4);
        return s;
    endfunction

    function automatic step_t cfg_row(input logic [scrs_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [scrs_pkg::TARGET_W-1:0] val);
        step_t s;
        s = '0;
        s.kind = STEP_CFG;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    task automatic send_byte(
        input logic [scrs_pkg::BYTE_W-1:0] b, input logic fin,
        input logic known,
        input logic [scrs_pkg::MAX_DIGITS-1:0][scrs_pkg::COEFF_W-1:0] known_coeffs);
        // Closes a configuration burst that may have ended at this edge.
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sample_byte(b, fin, known, known_coeffs);
        sent_since_drain = 1'b1;
    endtask

    // Keeps cfg_valid high so that writes can follow back to back.
    task automatic write_reg(input logic [scrs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [scrs_pkg::TARGET_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == scrs_pkg::CFG_ETA_MODE)
            eta_sel = val[scrs_pkg::ETA_W-1:0];
        else
            target_sel = val;
    endtask

    // Waits for every expected coefficient, then lets a byte that yields nothing clear out.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_coeffs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        sent_since_drain = 1'b0;
    endtask

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= ready_stall_pct);
    end

    always @(posedge clk)
    begin
        coeff_rec_t exp_rec;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_coeffs.size() == 0)
            begin
                $error("unexpected coefficient transfer: tdata %h", m_tdata);
                errors++;
            end
            else
            begin
                exp_rec = pending_coeffs.pop_front();
                if (m_tdata[scrs_pkg::COEFF_W-1:0] !== exp_rec.coeff)
                begin
                    $error("coeff: expected %0d, got %0d", $signed(exp_rec.coeff),
                           $signed(m_tdata[scrs_pkg::COEFF_W-1:0]));
                    errors++;
                end
                if (m_tdata[scrs_pkg::COEFF_W+scrs_pkg::INDEX_W-1:scrs_pkg::COEFF_W]
                    !== exp_rec.index)
                begin
                    $error("coeff_index: expected %0d, got %0d", exp_rec.index,
                           m_tdata[scrs_pkg::COEFF_W+scrs_pkg::INDEX_W-1:scrs_pkg::COEFF_W]);
                    errors++;
                end
                if (m_tlast !== exp_rec.last)
                begin
                    $error("last_of_byte: expected %0b, got %0b", exp_rec.last, m_tlast);
                    errors++;
                end
                if (m_tuser !== exp_rec.reached)
                begin
                    $error("target_reached: expected %0b, got %0b", exp_rec.reached, m_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        logic [scrs_pkg::ETA_W-1:0]    eta_pick;
        logic [scrs_pkg::TARGET_W-1:0] target_pick;
        logic                          fin;
        int                            n_items;
        int                            limit;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 28;
        ready_stall_pct = 85;
        sent_since_drain = 1'b0;
        eta_sel = scrs_pkg::ETA_MODE_1;
        target_sel = scrs_pkg::TARGET_RESET;
        coeff_count = '0;

        // Reset defaults first: eta-1 mode, target 256.
        script.push_back(known_row(8'd0,   1'b0, 0, 0, 0, 0, 0));
        script.push_back(known_row(8'd242, 1'b0, -1, -1, -1, -1, -1));
        script.push_back(byte_row(8'd243, 1'b0));
        script.push_back(byte_row(8'd255, 1'b0));
        script.push_back(known_row(8'd1,   1'b0, 1, 0, 0, 0, 0));
        script.push_back(known_row(8'd121, 1'b0, 1, 1, 1, 1, 1));
        script.push_back(cfg_row(scrs_pkg::CFG_ETA_MODE,
                                 scrs_pkg::TARGET_W'(scrs_pkg::ETA_MODE_2)));
        script.push_back(known_row(8'h00, 1'b0, 2, 2, 0, 0, 0));
        script.push_back(byte_row(8'hff, 1'b0));
        script.push_back(known_row(8'h4e, 1'b0, -2, -2, 0, 0, 0));
        script.push_back(known_row(8'hf3, 1'b0, -1, 0, 0, 0, 0));
        script.push_back(known_row(8'h3f, 1'b0, -1, 0, 0, 0, 0));
        script.push_back(byte_row(8'h5a, 1'b1));
        // Unused modes decode as eta-1.
        script.push_back(cfg_row(scrs_pkg::CFG_ETA_MODE, 11'd0));
        script.push_back(known_row(8'd5, 1'b0, -1, 1, 0, 0, 0));
        script.push_back(cfg_row(scrs_pkg::CFG_ETA_MODE, 11'd3));
        script.push_back(byte_row(8'd200, 1'b1));
        // Target of three reached inside a byte, then held until a final byte.
        script.push_back(cfg_row(scrs_pkg::CFG_ETA_MODE,
                                 scrs_pkg::TARGET_W'(scrs_pkg::ETA_MODE_1)));
        script.push_back(cfg_row(scrs_pkg::CFG_TARGET, 11'd3));
        script.push_back(known_row(8'd0, 1'b0, 0, 0, 0, 0, 0));
        script.push_back(byte_row(8'd7, 1'b0));
        script.push_back(byte_row(8'd250, 1'b1));
        script.push_back(known_row(8'd121, 1'b0, 1, 1, 1, 0, 0));
        script.push_back(cfg_row(scrs_pkg::CFG_TARGET, 11'd0));
        script.push_back(byte_row(8'd100, 1'b1));
        // Target lowered below the running count stays stopped until a final byte.
        script.push_back(cfg_row(scrs_pkg::CFG_TARGET, 11'd10));
        script.push_back(byte_row(8'd0, 1'b0));
        script.push_back(byte_row(8'd121, 1'b0));
        script.push_back(cfg_row(scrs_pkg::CFG_TARGET, 11'd4));
        script.push_back(byte_row(8'd0, 1'b0));
        script.push_back(byte_row(8'd9, 1'b1));
        script.push_back(byte_row(8'd200, 1'b0));
        script.push_back(cfg_row(scrs_pkg::CFG_TARGET, 11'd2047));
        script.push_back(byte_row(8'd128, 1'b1));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == STEP_CFG)
            begin
                if (sent_since_drain)
                    drain();
                write_reg(script[i].reg_idx, script[i].reg_val);
            end
            else
                send_byte(script[i].rand_byte, script[i].final_byte, script[i].known,
                          script[i].known_coeffs);
        end

        for (int p = 0; p < 9; p++)
        begin
            case (p / 3)
                0:
                begin
                    send_idle_pct = 28;
                    ready_stall_pct = 85;
                end
                1:
                begin
                    send_idle_pct = 85;
                    ready_stall_pct = 28;
                end
                default:
                begin
                    send_idle_pct = 0;
                    ready_stall_pct = 0;
                end
            endcase

            if (p == 8)
                eta_pick = scrs_pkg::ETA_W'($urandom_range(3));
            else
                eta_pick = (p % 2 == 0) ? scrs_pkg::ETA_MODE_1 : scrs_pkg::ETA_MODE_2;
            if (p == 4)
                target_pick = 11'd2047;
            else if (p == 1)
                target_pick = 11'd1024;
            else if (p == 2)
                target_pick = 11'd1;
            else
                target_pick = scrs_pkg::TARGET_W'($urandom_range(300, 1));

            // The sender holds off here until every coefficient has arrived.
            drain();
            write_reg(scrs_pkg::CFG_ETA_MODE, scrs_pkg::TARGET_W'(eta_pick));
            write_reg(scrs_pkg::CFG_TARGET, target_pick);

            // The long phase runs the count all the way to the array bound.
            n_items = (p == 4) ? 240 : 24;
            for (int k = 0; k < n_items; k++)
            begin
                limit = (int'(target_sel) > MAX_COEFFS) ? MAX_COEFFS : int'(target_sel);
                if (p == 4)
                    fin = (k == n_items - 1);
                else if (int'(coeff_count) >= limit)
                    fin = ($urandom_range(3) != 0);
                else
                    fin = ($urandom_range(24) == 0);
                send_byte(scrs_pkg::BYTE_W'($urandom_range(255)), fin, 1'b0, '0);
            end
        end

        drain();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
